>>> design/lj_pct_pkg.sv
// Shared types, codes and the square-root step for the LJ pair coefficient table.
// No dependencies; used by every module of the block.
package lj_pct_pkg;

  typedef enum logic [1:0] {
    KindClear = 2'd0,
    KindWrite = 2'd1,
    KindQuery = 2'd2
  } lj_kind_e;

  typedef enum logic [1:0] {
    CfgFormat = 2'd0,
    CfgMean   = 2'd1,
    CfgCount  = 2'd2
  } lj_cfg_e;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  type_first;
    logic [5:0]  type_second;
    logic [31:0] first_value;
    logic [31:0] second_value;
  } lj_in_t;

  typedef struct packed {
    logic        pair_defined;
    logic [63:0] coeff_repulsive;
    logic [63:0] coeff_attractive;
    logic        saturated;
  } lj_out_t;

  // Item context carried alongside the arithmetic
  typedef struct packed {
    logic        valid;
    logic        defined;
    logic        ab;
    logic        mean;
    logic        zero;
    logic        cr;
    logic        ce;
    logic [39:0] rep_ab;
    logic [39:0] att_ab;
    logic [32:0] rsum;
    logic [32:0] r;
    logic [31:0] eps;
    logic [63:0] r6;
    logic [63:0] e6;
  } lj_side_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] rest;
  } lj_sqrt_t;

  // One restoring digit of the integer square root
  function automatic lj_sqrt_t sqrt_step(lj_sqrt_t s);
    lj_sqrt_t    o;
    logic [34:0] acc;
    logic [34:0] trial;
    acc    = {s.rem[32:0], s.rest[63:62]};
    trial  = {1'b0, s.root, 2'b01};
    o.rest = {s.rest[61:0], 2'b00};
    if (acc >= trial) begin
      o.rem  = acc - trial;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = acc;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> design/lj_pair_coefficient_table.sv
// LJ pair coefficient table: pipelined from accepted beat to result beat.
// Throughput one beat per cycle; the whole pipeline advances together and only
// holds while a finished result sits unaccepted in the output register.
// Reset clears the defined marks, the registers and all valid bits; the value
// tables are not cleared and read as undefined until written.
module lj_pair_coefficient_table #(
  parameter int MaxTypes = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item channel
  input  logic                                in_valid_i,
  input  lj_pct_pkg::lj_in_t                  in_data_i,
  output logic                                stall_o,
  // result channel
  output logic                                out_valid_o,
  output lj_pct_pkg::lj_out_t                 out_data_o,
  input  logic                                stall_i,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lj_pct_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [lj_pct_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int IdxW = $clog2(MaxTypes);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic       fmt_q, mean_q;
  logic [6:0] count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= 1'b0;
      mean_q  <= 1'b0;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      case (lj_pct_pkg::lj_cfg_e'(cfg_index_i))
        lj_pct_pkg::CfgFormat: fmt_q   <= cfg_data_i[0];
        lj_pct_pkg::CfgMean:   mean_q  <= cfg_data_i[0];
        lj_pct_pkg::CfgCount:  count_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: one enable for every stage, output register as the skid
  // ---------------------------------------------------------------------------
  logic en, accept;

  assign en      = !out_valid_o || !stall_i;
  assign stall_o = !en;
  assign accept  = in_valid_i && en;

  // ---------------------------------------------------------------------------
  // Type table and defined marks
  // ---------------------------------------------------------------------------
  logic [31:0]         first_mem  [MaxTypes];
  logic [31:0]         second_mem [MaxTypes];
  logic [MaxTypes-1:0] marks_q;

  logic [IdxW-1:0] idx_a, idx_b;
  logic            rng_a, rng_b, is_write, is_clear, is_query, pair_ok;

  assign idx_a    = IdxW'(in_data_i.type_first);
  assign idx_b    = IdxW'(in_data_i.type_second);
  assign rng_a    = (32'(in_data_i.type_first) < 32'(MaxTypes));
  assign rng_b    = (32'(in_data_i.type_second) < 32'(MaxTypes));
  assign is_clear = (in_data_i.kind == lj_pct_pkg::KindClear);
  assign is_write = (in_data_i.kind == lj_pct_pkg::KindWrite);
  assign is_query = (in_data_i.kind == lj_pct_pkg::KindQuery);

  // in range of type_count and of the table, and both marked
  assign pair_ok = rng_a && rng_b
                && ({1'b0, in_data_i.type_first} < count_q)
                && ({1'b0, in_data_i.type_second} < count_q)
                && marks_q[idx_a] && marks_q[idx_b];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '0;
    end else if (accept) begin
      if (is_clear) begin
        marks_q <= '0;
      end else if (is_write && rng_a) begin
        marks_q[idx_a] <= 1'b1;
      end
    end
  end

  // stage 1: registered reads of both entries
  logic [31:0]          fi_q, fj_q, si_q, sj_q;
  lj_pct_pkg::lj_side_t s1_q, s1_d;

  always_ff @(posedge clk_i) begin
    if (accept && is_write && rng_a) begin
      first_mem[idx_a]  <= in_data_i.first_value;
      second_mem[idx_a] <= in_data_i.second_value;
    end
    if (en) begin
      fi_q <= first_mem[idx_a];
      fj_q <= first_mem[idx_b];
      si_q <= second_mem[idx_a];
      sj_q <= second_mem[idx_b];
    end
  end

  always_comb begin
    s1_d         = '0;
    s1_d.valid   = accept;
    s1_d.defined = is_query && pair_ok;
    s1_d.ab      = fmt_q;
    s1_d.mean    = mean_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: eps and radius radicands, A/B products, radius sum
  // ---------------------------------------------------------------------------
  logic [63:0]          pe_q, ps_q;
  lj_pct_pkg::lj_side_t s2_q, s2_d;

  always_comb begin
    logic [63:0] pe, ps;
    pe          = fi_q * fj_q;
    ps          = si_q * sj_q;
    s2_d        = s1_q;
    s2_d.rep_ab = pe[63:24];
    s2_d.att_ab = ps[63:24];
    s2_d.rsum   = {1'b0, si_q} + {1'b0, sj_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pe_q <= fi_q * fj_q;
      ps_q <= si_q * sj_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3-10: square roots
  // ---------------------------------------------------------------------------
  logic [31:0]          root_e, root_s;
  lj_pct_pkg::lj_side_t s3, q1_in;

  lj_isqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .val_e_i  (pe_q),
    .val_s_i  (ps_q),
    .side_i   (s2_q),
    .root_e_o (root_e),
    .root_s_o (root_s),
    .side_o   (s3)
  );

  always_comb begin
    q1_in      = s3;
    q1_in.eps  = root_e;
    q1_in.r    = s3.mean ? {root_s, 1'b0} : s3.rsum;
    q1_in.zero = (root_e == '0) || (q1_in.r == '0);
    q1_in.cr   = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stages 11-20: R^2, R^3, R^6, eps*R^6, eps*R^12
  // ---------------------------------------------------------------------------
  logic [63:0]          p1, p2, p3, p4, p5;
  logic                 c1, c2, c3, c4, c5;
  lj_pct_pkg::lj_side_t o1, o2, o3, o4, o5;
  lj_pct_pkg::lj_side_t i2, i3, i4, i5;

  lj_qmul u_r2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i ({31'd0, q1_in.r}), .b_i ({31'd0, q1_in.r}), .side_i (q1_in),
    .p_o (p1), .clamp_o (c1), .side_o (o1)
  );

  always_comb begin
    i2    = o1;
    i2.cr = c1;
  end

  lj_qmul u_r3 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i (p1), .b_i ({31'd0, o1.r}), .side_i (i2),
    .p_o (p2), .clamp_o (c2), .side_o (o2)
  );

  always_comb begin
    i3    = o2;
    i3.cr = o2.cr || c2;
  end

  lj_qmul u_r6 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i (p2), .b_i (p2), .side_i (i3),
    .p_o (p3), .clamp_o (c3), .side_o (o3)
  );

  always_comb begin
    i4    = o3;
    i4.cr = o3.cr || c3;
    i4.r6 = p3;
  end

  lj_qmul u_e6 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i ({32'd0, o3.eps}), .b_i (p3), .side_i (i4),
    .p_o (p4), .clamp_o (c4), .side_o (o4)
  );

  always_comb begin
    i5    = o4;
    i5.ce = o4.cr || c4;
    i5.e6 = p4;
  end

  lj_qmul u_rep (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i (p4), .b_i (o4.r6), .side_i (i5),
    .p_o (p5), .clamp_o (c5), .side_o (o5)
  );

  // ---------------------------------------------------------------------------
  // Stage 21: result selection into the output register
  // ---------------------------------------------------------------------------
  logic                out_valid_q;
  lj_pct_pkg::lj_out_t out_q, out_d;

  always_comb begin
    logic ca, cb;
    ca    = o5.ce || c5;
    cb    = o5.ce || o5.e6[63];
    out_d = '0;
    if (o5.defined) begin
      out_d.pair_defined = 1'b1;
      if (o5.ab) begin
        out_d.coeff_repulsive  = {24'd0, o5.rep_ab};
        out_d.coeff_attractive = {24'd0, o5.att_ab};
      end else if (!o5.zero) begin
        // saturation wins over the computed value
        out_d.coeff_attractive = cb ? '1 : {o5.e6[62:0], 1'b0};
        out_d.coeff_repulsive  = ca ? '1 : p5;
        out_d.saturated        = ca || cb;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= o5.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/lj_isqrt.sv
// Two-lane pipelined floor square root, 64-bit radicand, 4 digits per stage.
// Depends on lj_pct_pkg.
module lj_isqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [63:0]          val_e_i,
  input  logic [63:0]          val_s_i,
  input  lj_pct_pkg::lj_side_t side_i,
  output logic [31:0]          root_e_o,
  output logic [31:0]          root_s_o,
  output lj_pct_pkg::lj_side_t side_o
);

  localparam int Stages = 8;
  localparam int Steps  = 4;

  lj_pct_pkg::lj_sqrt_t st_q  [2][Stages];
  lj_pct_pkg::lj_sqrt_t src   [2][Stages];
  lj_pct_pkg::lj_sqrt_t nxt   [2][Stages];
  lj_pct_pkg::lj_side_t side_q[Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign src[0][s] = '{rem: '0, root: '0, rest: val_e_i};
      assign src[1][s] = '{rem: '0, root: '0, rest: val_s_i};
    end else begin : g_next
      assign src[0][s] = st_q[0][s-1];
      assign src[1][s] = st_q[1][s-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      always_comb begin
        lj_pct_pkg::lj_sqrt_t t;
        t = src[l][s];
        for (int k = 0; k < Steps; k++) begin
          t = lj_pct_pkg::sqrt_step(t);
        end
        nxt[l][s] = t;
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          st_q[l][s] <= nxt[l][s];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else if (en_i) begin
        side_q[s] <= (s == 0) ? side_i : side_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign root_e_o = st_q[0][Stages-1].root;
  assign root_s_o = st_q[1][Stages-1].root;
  assign side_o   = side_q[Stages-1];

endmodule

>>> design/lj_qmul.sv
// Two-stage Q.24 multiply, 64x64 via four 32x32 partials, clamps to all ones.
// Depends on lj_pct_pkg.
module lj_qmul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [63:0]          a_i,
  input  logic [63:0]          b_i,
  input  lj_pct_pkg::lj_side_t side_i,
  output logic [63:0]          p_o,
  output logic                 clamp_o,
  output lj_pct_pkg::lj_side_t side_o
);

  logic [63:0]          ll_q, lh_q, hl_q, hh_q;
  logic [63:0]          p_q;
  logic                 clamp_q;
  logic [127:0]         full;
  lj_pct_pkg::lj_side_t side1_q, side2_q;

  assign full = {hh_q, 64'd0} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0}
              + {64'd0, ll_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q    <= a_i[31:0]  * b_i[31:0];
      lh_q    <= a_i[31:0]  * b_i[63:32];
      hl_q    <= a_i[63:32] * b_i[31:0];
      hh_q    <= a_i[63:32] * b_i[63:32];
      clamp_q <= (full[127:88] != '0);
      p_q     <= (full[127:88] != '0) ? '1 : full[87:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
    end else if (en_i) begin
      side1_q <= side_i;
      side2_q <= side1_q;
    end
  end

  assign p_o     = p_q;
  assign clamp_o = clamp_q;
  assign side_o  = side2_q;

endmodule

>>> design/lj_pct_checker.sv
// Port-level checks for the LJ pair coefficient table, bound to the top level.
// Depends on lj_pct_pkg and lj_pair_coefficient_table.
module lj_pct_assert (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                stall_o,
  input logic                out_valid_o,
  input lj_pct_pkg::lj_out_t out_data_o,
  input logic                stall_i
);

  // a held result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // input only stalls behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !stall_o)
    else $error("input stalled with empty output");

  // undefined pair gives all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.pair_defined |->
      out_data_o.coeff_repulsive == '0 && out_data_o.coeff_attractive == '0
      && !out_data_o.saturated)
    else $error("undefined pair with non-zero result");

  // saturation flag implies a clamped coefficient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.pair_defined
      && (out_data_o.coeff_repulsive == '1 || out_data_o.coeff_attractive == '1))
    else $error("saturation flag without clamped coefficient");

endmodule

bind lj_pair_coefficient_table lj_pct_assert u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .stall_o     (stall_o),
  .out_valid_o (out_valid_o),
  .out_data_o  (out_data_o),
  .stall_i     (stall_i)
);
